>>> rtl/xyz_to_srgb_pixel_converter_macros.svh
// ----------------------------------------------------------------------------
// XYZ to sRGB converter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef XYZ_TO_SRGB_PIXEL_CONVERTER_MACROS_SVH
`define XYZ_TO_SRGB_PIXEL_CONVERTER_MACROS_SVH

// Expression must hold at every edge out of reset.
`define XTSC_CHECK(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define XTSC_CHECK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/xtsc_pkg.sv
// ----------------------------------------------------------------------------
// XYZ to sRGB converter package
// Widths, fixed-point constants, register codes and lane structs.
// ----------------------------------------------------------------------------
package xtsc_pkg;

    localparam int NUM_CH    = 3;
    localparam int CH_R      = 0;
    localparam int CH_G      = 1;
    localparam int CH_B      = 2;

    localparam int IN_W      = 17;
    localparam int OUT_W     = 16;
    localparam int ROW_W     = 54;
    localparam int COEF_W    = 18;
    localparam int PROD_W    = COEF_W + IN_W + 1;
    localparam int SUM_W     = PROD_W + 1;
    localparam int FRAC_W    = 30;
    localparam int LIN_W     = FRAC_W + 1;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_RED   = 2'd0,
        REG_ROW_GREEN = 2'd1,
        REG_ROW_BLUE  = 2'd2
    } reg_idx_t;

    // D65 matrix rows, Q3.14 coefficients packed x, y, z from the bottom
    localparam logic [ROW_W-1:0] ROW_RED_RST   = 54'd17453091221196646;
    localparam logic [ROW_W-1:0] ROW_GREEN_RST = 54'd46737300898302;
    localparam logic [ROW_W-1:0] ROW_BLUE_RST  = 54'd1190151741506449;

    // root units
    localparam int SQ_ROOT_W = 31;
    localparam int SQ_RAD_W  = LIN_W + FRAC_W;
    localparam int CB_ROOT_W = 21;
    localparam int CB_RAD_W  = SQ_ROOT_W + FRAC_W;

    // linear segment: v <= 0.0031308 in Q.30, out = round(v * 12.92 * 65535)
    localparam logic [LIN_W-1:0] LIN_KNEE  = 31'd3361670;
    localparam int               LW_W      = 27;
    localparam logic [26:0]      LIN_GAIN  = 27'd84671220;
    localparam logic [57:0]      LIN_RND   = 58'd50 << FRAC_W;
    localparam logic [25:0]      DIV100_M  = 26'd42949673;
    localparam int               DIV100_SH = 32;

    // power segment: 1.055 * v^(1/2.4) - 0.055, y in Q0.32
    localparam int               Y_W        = 33;
    localparam int               N_W        = 44;
    localparam logic [10:0]      POW_GAIN   = 11'd1055;
    localparam logic [N_W-1:0]   POW_OFS    = 44'd55 << 32;
    localparam logic [59:0]      OUT_RND    = 60'd500 << 32;
    localparam int               W2_W       = 28;
    localparam logic [28:0]      DIV1000_M  = 29'd274877907;
    localparam int               DIV1000_SH = 38;
    localparam logic [18:0]      OUT_MAX    = 19'd65535;

    typedef struct packed {
        logic             vld;
        logic             flag;
        logic [LIN_W-1:0] v;
    } lin_t;

    typedef struct packed {
        logic             sel;
        logic [OUT_W-1:0] lin;
        logic             flag;
    } side_t;

    typedef struct packed {
        logic             vld;
        logic             flag;
        logic [OUT_W-1:0] value;
    } enc_t;

endpackage

>>> rtl/xtsc_pixel_if.sv
// ----------------------------------------------------------------------------
// XYZ to sRGB converter stream interfaces
// Valid/ready channels for XYZ pixels in and encoded RGB pixels out.
// ----------------------------------------------------------------------------
interface xtsc_xyz_if;
    logic                      valid;
    logic                      ready;
    logic [xtsc_pkg::IN_W-1:0] x_in;
    logic [xtsc_pkg::IN_W-1:0] y_in;
    logic [xtsc_pkg::IN_W-1:0] z_in;

    modport source (output valid, output x_in, output y_in, output z_in, input ready);
    modport sink   (input valid, input x_in, input y_in, input z_in, output ready);
endinterface

interface xtsc_rgb_if;
    logic                       valid;
    logic                       ready;
    logic [xtsc_pkg::OUT_W-1:0] red_out;
    logic [xtsc_pkg::OUT_W-1:0] green_out;
    logic [xtsc_pkg::OUT_W-1:0] blue_out;
    logic [2:0]                 clip_flags;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output clip_flags, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input clip_flags, output ready);
endinterface

>>> rtl/xyz_to_srgb_pixel_converter.sv
// ----------------------------------------------------------------------------
// CIE XYZ to sRGB pixel converter
// Throughput: one pixel per cycle unless the output stalls; the fourth-root
// square-root pipe, one root bit per stage, sets the depth.
// Stall: the pipeline holds only while a result waits and its last stage is
// full; empty slots collapse into a waiting output.
// Reset: the pipeline empties and the rows load the D65 matrix.
// ----------------------------------------------------------------------------
`include "xyz_to_srgb_pixel_converter_macros.svh"

module xyz_to_srgb_pixel_converter (
    input  logic                               clk,
    input  logic                               rst_n,
    xtsc_xyz_if.sink                           xyz,
    xtsc_rgb_if.source                         rgb,
    input  logic                               cfg_we,
    input  logic [xtsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [xtsc_pkg::ROW_W-1:0]         cfg_data
);

    localparam int NCH = xtsc_pkg::NUM_CH;
    localparam int OW  = xtsc_pkg::OUT_W;

    logic [xtsc_pkg::ROW_W-1:0] row_reg [NCH];
    logic [xtsc_pkg::IN_W-1:0]  xyz_val [NCH];
    xtsc_pkg::lin_t             lin     [NCH];
    xtsc_pkg::enc_t             enc     [NCH];
    logic                       adv;
    logic                       load_out;

    logic                       out_vld_reg;
    logic [OW-1:0]              red_reg;
    logic [OW-1:0]              green_reg;
    logic [OW-1:0]              blue_reg;
    logic [2:0]                 clip_reg;

    // configuration rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[xtsc_pkg::CH_R] <= xtsc_pkg::ROW_RED_RST;
            row_reg[xtsc_pkg::CH_G] <= xtsc_pkg::ROW_GREEN_RST;
            row_reg[xtsc_pkg::CH_B] <= xtsc_pkg::ROW_BLUE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                xtsc_pkg::REG_ROW_RED:   row_reg[xtsc_pkg::CH_R] <= cfg_data;
                xtsc_pkg::REG_ROW_GREEN: row_reg[xtsc_pkg::CH_G] <= cfg_data;
                xtsc_pkg::REG_ROW_BLUE:  row_reg[xtsc_pkg::CH_B] <= cfg_data;
                default:                 ;
            endcase
        end
    end

    // advance unless a result waits and the last stage is full
    assign load_out  = rgb.ready || !out_vld_reg;
    assign adv       = load_out || !enc[xtsc_pkg::CH_R].vld;
    assign xyz.ready = adv;

    assign xyz_val[xtsc_pkg::CH_R] = xyz.x_in;
    assign xyz_val[xtsc_pkg::CH_G] = xyz.y_in;
    assign xyz_val[xtsc_pkg::CH_B] = xyz.z_in;

    xtsc_matrix u_matrix (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .vld     (xyz.valid),
        .xyz_val (xyz_val),
        .rows    (row_reg),
        .lin     (lin)
    );

    for (genvar ch = 0; ch < NCH; ch++) begin : g_chan
        xtsc_gamma_chan u_gamma (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .lin   (lin[ch]),
            .enc   (enc[ch])
        );
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_vld_reg <= enc[xtsc_pkg::CH_R].vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            red_reg   <= enc[xtsc_pkg::CH_R].value;
            green_reg <= enc[xtsc_pkg::CH_G].value;
            blue_reg  <= enc[xtsc_pkg::CH_B].value;
            clip_reg  <= {enc[xtsc_pkg::CH_B].flag, enc[xtsc_pkg::CH_G].flag,
                          enc[xtsc_pkg::CH_R].flag};
        end
    end

    assign rgb.valid      = out_vld_reg;
    assign rgb.red_out    = red_reg;
    assign rgb.green_out  = green_reg;
    assign rgb.blue_out   = blue_reg;
    assign rgb.clip_flags = clip_reg;

    `XTSC_CHECK(a_lanes_in_step, (enc[xtsc_pkg::CH_R].vld == enc[xtsc_pkg::CH_G].vld) && (enc[xtsc_pkg::CH_R].vld == enc[xtsc_pkg::CH_B].vld), "channel lanes out of step")
    `XTSC_CHECK_IMPL(a_stall_cause, !xyz.ready, rgb.valid && !rgb.ready, "input held without a waiting result")
    `XTSC_CHECK_IMPL(a_clip_red, rgb.valid && rgb.clip_flags[0], rgb.red_out == 16'h0000 || rgb.red_out == 16'hFFFF, "clipped red not at a rail")
    `XTSC_CHECK_IMPL(a_clip_green, rgb.valid && rgb.clip_flags[1], rgb.green_out == 16'h0000 || rgb.green_out == 16'hFFFF, "clipped green not at a rail")
    `XTSC_CHECK_IMPL(a_clip_blue, rgb.valid && rgb.clip_flags[2], rgb.blue_out == 16'h0000 || rgb.blue_out == 16'hFFFF, "clipped blue not at a rail")

endmodule

>>> rtl/xtsc_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One result bit per register stage, restoring digit recurrence, floor root.
// ----------------------------------------------------------------------------
module xtsc_sqrt_pipe #(
    parameter int RAD_W  = xtsc_pkg::SQ_RAD_W,
    parameter int ROOT_W = xtsc_pkg::SQ_ROOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              vld,
    input  logic [RAD_W-1:0]  rad,
    output logic              root_vld,
    output logic [ROOT_W-1:0] root
);

    localparam int DW = 2 * ROOT_W + 1;

    logic [DW-1:0]     rem_reg  [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;

        logic [DW-1:0]     rem_cur;
        logic [DW-1:0]     trial;
        logic              take;
        logic [ROOT_W-1:0] root_cur;
        logic [ROOT_W-1:0] root_next;
        logic              vld_cur;

        if (k == 0) begin : g_first
            assign rem_cur  = DW'(rad);
            assign root_cur = '0;
            assign vld_cur  = vld;
        end
        else begin : g_later
            assign rem_cur  = rem_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // (r + 2^b)^2 - r^2
        always_comb
        begin
            trial     = (DW'(root_cur) << (B + 1)) + (DW'(1) << (2 * B));
            take      = (rem_cur >= trial);
            root_next = take ? (root_cur | (ROOT_W'(1) << B)) : root_cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg[k] <= root_next;
            end
        end

        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= take ? (rem_cur - trial) : rem_cur;
                end
            end
        end
    end

    assign root_vld = vld_reg[ROOT_W-1];
    assign root     = root_reg[ROOT_W-1];

endmodule

>>> rtl/xtsc_cbrt_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined integer cube root
// One result bit per register stage; the running square of the root is kept
// so each stage needs only shifts and adds.
// ----------------------------------------------------------------------------
module xtsc_cbrt_pipe #(
    parameter int RAD_W  = xtsc_pkg::CB_RAD_W,
    parameter int ROOT_W = xtsc_pkg::CB_ROOT_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              vld,
    input  logic [RAD_W-1:0]  rad,
    output logic              root_vld,
    output logic [ROOT_W-1:0] root
);

    localparam int DW = 3 * ROOT_W + 1;
    localparam int SW = 2 * ROOT_W;

    logic [DW-1:0]     rem_reg  [ROOT_W-1];
    logic [SW-1:0]     sq_reg   [ROOT_W-1];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic              vld_reg  [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_step
        localparam int B = ROOT_W - 1 - k;

        logic [DW-1:0]     rem_cur;
        logic [SW-1:0]     sq_cur;
        logic [DW-1:0]     t_sq;
        logic [DW-1:0]     t_rt;
        logic [DW-1:0]     trial;
        logic              take;
        logic [ROOT_W-1:0] root_cur;
        logic [ROOT_W-1:0] root_next;
        logic              vld_cur;

        if (k == 0) begin : g_first
            assign rem_cur  = DW'(rad);
            assign sq_cur   = '0;
            assign root_cur = '0;
            assign vld_cur  = vld;
        end
        else begin : g_later
            assign rem_cur  = rem_reg[k-1];
            assign sq_cur   = sq_reg[k-1];
            assign root_cur = root_reg[k-1];
            assign vld_cur  = vld_reg[k-1];
        end

        // (r + 2^b)^3 - r^3 = 3 r^2 2^b + 3 r 2^2b + 2^3b
        always_comb
        begin
            t_sq      = DW'(sq_cur) << B;
            t_rt      = DW'(root_cur) << (2 * B);
            trial     = t_sq + (t_sq << 1) + t_rt + (t_rt << 1) + (DW'(1) << (3 * B));
            take      = (rem_cur >= trial);
            root_next = take ? (root_cur | (ROOT_W'(1) << B)) : root_cur;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                vld_reg[k] <= vld_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                root_reg[k] <= root_next;
            end
        end

        if (k < ROOT_W - 1) begin : g_rem
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k] <= take ? (rem_cur - trial) : rem_cur;
                    sq_reg[k]  <= take ? (sq_cur + (SW'(root_cur) << (B + 1))
                                          + (SW'(1) << (2 * B)))
                                       : sq_cur;
                end
            end
        end
    end

    assign root_vld = vld_reg[ROOT_W-1];
    assign root     = root_reg[ROOT_W-1];

endmodule

>>> rtl/xtsc_matrix.sv
// ----------------------------------------------------------------------------
// XYZ to linear RGB matrix
// Three stages: coefficient products, row sums, clamp to [0,1] with clip flag.
// ----------------------------------------------------------------------------
module xtsc_matrix (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  logic                         vld,
    input  logic [xtsc_pkg::IN_W-1:0]    xyz_val [xtsc_pkg::NUM_CH],
    input  logic [xtsc_pkg::ROW_W-1:0]   rows    [xtsc_pkg::NUM_CH],
    output xtsc_pkg::lin_t               lin     [xtsc_pkg::NUM_CH]
);

    localparam int NCH    = xtsc_pkg::NUM_CH;
    localparam int CW     = xtsc_pkg::COEF_W;
    localparam int PW     = xtsc_pkg::PROD_W;
    localparam int SW     = xtsc_pkg::SUM_W;
    localparam int LW     = xtsc_pkg::LIN_W;
    localparam logic signed [SW-1:0] ONE_S = SW'(64'd1 << xtsc_pkg::FRAC_W);

    logic signed [PW-1:0] prod_reg [NCH][NCH];
    logic signed [SW-1:0] sum_reg  [NCH];
    xtsc_pkg::lin_t       lin_reg  [NCH];
    logic                 prod_vld_reg;
    logic                 sum_vld_reg;
    logic                 lin_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
            lin_vld_reg  <= 1'b0;
        end
        else if (adv)
        begin
            prod_vld_reg <= vld;
            sum_vld_reg  <= prod_vld_reg;
            lin_vld_reg  <= sum_vld_reg;
        end
    end

    for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
        logic signed [SW-1:0] sum_next;
        logic [LW-1:0]        v_next;
        logic                 flag_next;

        for (genvar j = 0; j < NCH; j++) begin : g_term
            logic signed [CW-1:0] coef;
            logic signed [CW-1:0] op;
            logic signed [PW-1:0] prod_next;

            assign coef      = $signed(rows[ch][CW*j +: CW]);
            assign op        = $signed({1'b0, xyz_val[j]});
            assign prod_next = PW'(coef) * PW'(op);

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    prod_reg[ch][j] <= prod_next;
                end
            end
        end

        always_comb
        begin
            sum_next = SW'(prod_reg[ch][0]) + SW'(prod_reg[ch][1]) + SW'(prod_reg[ch][2]);
        end

        // clamp, flag only values strictly outside [0,1]
        always_comb
        begin
            if (sum_reg[ch] < 0)
            begin
                v_next    = '0;
                flag_next = 1'b1;
            end
            else if (sum_reg[ch] > ONE_S)
            begin
                v_next    = ONE_S[LW-1:0];
                flag_next = 1'b1;
            end
            else
            begin
                v_next    = sum_reg[ch][LW-1:0];
                flag_next = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sum_reg[ch]      <= sum_next;
                lin_reg[ch].v    <= v_next;
                lin_reg[ch].flag <= flag_next;
            end
        end

        always_comb
        begin
            lin[ch].vld  = lin_vld_reg;
            lin[ch].flag = lin_reg[ch].flag;
            lin[ch].v    = lin_reg[ch].v;
        end
    end

endmodule

>>> rtl/xtsc_gamma_chan.sv
// ----------------------------------------------------------------------------
// sRGB transfer curve, one channel
// Power segment: v^(1/2), then v^(1/4) and v^(1/6) in parallel root pipes,
// product, scale and offset, divide by 1000. The linear segment runs beside
// it and travels down a side delay line to the final select.
// ----------------------------------------------------------------------------
module xtsc_gamma_chan (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           adv,
    input  xtsc_pkg::lin_t lin,
    output xtsc_pkg::enc_t enc
);

    localparam int SQ_W   = xtsc_pkg::SQ_ROOT_W;
    localparam int CB_W   = xtsc_pkg::CB_ROOT_W;
    localparam int FW     = xtsc_pkg::FRAC_W;
    localparam int LWW    = xtsc_pkg::LW_W;
    localparam int YW     = xtsc_pkg::Y_W;
    localparam int NW     = xtsc_pkg::N_W;
    localparam int W2W    = xtsc_pkg::W2_W;
    localparam int OW     = xtsc_pkg::OUT_W;
    localparam int C_DLY  = SQ_W - CB_W;
    localparam int SB_DLY = 2 * SQ_W + 2;
    localparam int QC_W   = SQ_W + CB_W;

    // ---------------- linear segment ----------------
    logic [57:0]             lin_prod;
    logic [LWW-1:0]          l1_w_next;
    logic [LWW-1:0]          l1_w_reg;
    logic                    l1_sel_reg;
    logic                    l1_flag_reg;
    logic [52:0]             lin_quo;
    xtsc_pkg::side_t         side_next;
    xtsc_pkg::side_t         side_reg [SB_DLY];

    always_comb
    begin
        lin_prod  = 58'(lin.v) * 58'(xtsc_pkg::LIN_GAIN) + xtsc_pkg::LIN_RND;
        l1_w_next = lin_prod[FW +: LWW];
        lin_quo   = 53'(l1_w_reg) * 53'(xtsc_pkg::DIV100_M);
        side_next.sel  = l1_sel_reg;
        side_next.lin  = lin_quo[xtsc_pkg::DIV100_SH +: OW];
        side_next.flag = l1_flag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l1_w_reg    <= l1_w_next;
            l1_sel_reg  <= (lin.v <= xtsc_pkg::LIN_KNEE);
            l1_flag_reg <= lin.flag;
            side_reg[0] <= side_next;
            for (int i = 1; i < SB_DLY; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // ---------------- root pipes ----------------
    logic             s_vld;
    logic [SQ_W-1:0]  s_root;
    logic             q_vld;
    logic [SQ_W-1:0]  q_root;
    logic             c_vld;
    logic [CB_W-1:0]  c_root;

    xtsc_sqrt_pipe #(
        .RAD_W  (xtsc_pkg::SQ_RAD_W),
        .ROOT_W (SQ_W)
    ) u_sqrt_s (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld      (lin.vld),
        .rad      ({lin.v, FW'(0)}),
        .root_vld (s_vld),
        .root     (s_root)
    );

    xtsc_sqrt_pipe #(
        .RAD_W  (xtsc_pkg::SQ_RAD_W),
        .ROOT_W (SQ_W)
    ) u_sqrt_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld      (s_vld),
        .rad      ({s_root, FW'(0)}),
        .root_vld (q_vld),
        .root     (q_root)
    );

    xtsc_cbrt_pipe #(
        .RAD_W  (xtsc_pkg::CB_RAD_W),
        .ROOT_W (CB_W)
    ) u_cbrt_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld      (s_vld),
        .rad      ({s_root, FW'(0)}),
        .root_vld (c_vld),
        .root     (c_root)
    );

    // align the shorter cube root pipe with the fourth root
    logic [CB_W-1:0] c_dly_reg [C_DLY];
    logic            cv_dly_reg [C_DLY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < C_DLY; i++)
            begin
                cv_dly_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            cv_dly_reg[0] <= c_vld;
            for (int i = 1; i < C_DLY; i++)
            begin
                cv_dly_reg[i] <= cv_dly_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_dly_reg[0] <= c_root;
            for (int i = 1; i < C_DLY; i++)
            begin
                c_dly_reg[i] <= c_dly_reg[i-1];
            end
        end
    end

    // ---------------- power tail ----------------
    logic [QC_W-1:0] qc_prod;
    logic [YW-1:0]   y_next;
    logic [YW-1:0]   y_reg;
    logic [NW-1:0]   a_prod;
    logic [NW-1:0]   n_next;
    logic [NW-1:0]   n_reg;
    logic [59:0]     scaled;
    logic [W2W-1:0]  w2_next;
    logic [W2W-1:0]  w2_reg;
    logic [56:0]     quo;
    logic [18:0]     pow_q;
    logic [OW-1:0]   pow_out;
    logic [OW-1:0]   res_next;
    logic [OW-1:0]   res_reg;
    logic            flag_reg;
    logic [3:0]      p_vld_reg;

    always_comb
    begin
        qc_prod  = QC_W'(q_root) * QC_W'(c_dly_reg[C_DLY-1]) + (QC_W'(1) << 17);
        y_next   = qc_prod[18 +: YW];
        a_prod   = NW'(y_reg) * NW'(xtsc_pkg::POW_GAIN);
        n_next   = (a_prod > xtsc_pkg::POW_OFS) ? (a_prod - xtsc_pkg::POW_OFS) : '0;
        scaled   = (60'(n_reg) << 16) - 60'(n_reg) + xtsc_pkg::OUT_RND;
        w2_next  = scaled[32 +: W2W];
        quo      = 57'(w2_reg) * 57'(xtsc_pkg::DIV1000_M);
        pow_q    = quo[xtsc_pkg::DIV1000_SH +: 19];
        pow_out  = (pow_q > xtsc_pkg::OUT_MAX) ? '1 : pow_q[OW-1:0];
        res_next = side_reg[SB_DLY-1].sel ? side_reg[SB_DLY-1].lin : pow_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= '0;
        end
        else if (adv)
        begin
            p_vld_reg <= {p_vld_reg[2:0], q_vld & cv_dly_reg[C_DLY-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y_reg    <= y_next;
            n_reg    <= n_next;
            w2_reg   <= w2_next;
            res_reg  <= res_next;
            flag_reg <= side_reg[SB_DLY-1].flag;
        end
    end

    always_comb
    begin
        enc.vld   = p_vld_reg[3];
        enc.flag  = flag_reg;
        enc.value = res_reg;
    end

endmodule
